// ===== rtl/pisd_pkg.sv =====
// ----------------------------------------------------------------------------
// pisd_pkg
// Shared types and constants for the packed image stream decoder.
// ----------------------------------------------------------------------------
package pisd_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BAD_ID = 2'd1,
    ERR_OFFSET = 2'd2
  } err_e;

  localparam logic [7:0]  TAG_BYTES [4] = '{8'h47, 8'h46, 8'h58, 8'h30};
  localparam logic [31:0] COLOUR_DEFAULT = 32'hFF00_0000;
  localparam int unsigned CHAN_ALPHA = 3;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    err_e        error_code;
    logic        last_of_image;
  } res_t;

endpackage

// ===== rtl/pisd_in_if.sv =====
// ----------------------------------------------------------------------------
// pisd_in_if
// Byte request channel into the decoder.
// ----------------------------------------------------------------------------
interface pisd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink   (input valid, input data_byte, input start_of_image, output ready);
endinterface

// ===== rtl/pisd_out_if.sv =====
// ----------------------------------------------------------------------------
// pisd_out_if
// Result request channel out of the decoder.
// ----------------------------------------------------------------------------
interface pisd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        has_alpha;
  logic [1:0]  error_code;
  logic        last_of_image;

  modport source (
    output valid, output kind, output pixel_index, output red, output green,
    output blue, output alpha, output image_width, output image_height,
    output has_alpha, output error_code, output last_of_image, input ready
  );
  modport sink (
    input valid, input kind, input pixel_index, input red, input green,
    input blue, input alpha, input image_width, input image_height,
    input has_alpha, input error_code, input last_of_image, output ready
  );
endinterface

// ===== rtl/pisd_parser.sv =====
// ----------------------------------------------------------------------------
// pisd_parser
// Byte-wise parser state and per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module pisd_parser import pisd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [3:0] {
    PH_ID      = 4'd0,
    PH_FLAGS   = 4'd1,
    PH_WIDTH   = 4'd2,
    PH_HEIGHT  = 4'd3,
    PH_NBLOCKS = 4'd4,
    PH_RAW     = 4'd5,
    PH_BFLAGS  = 4'd6,
    PH_BCOLOUR = 4'd7,
    PH_BCOUNT  = 4'd8,
    PH_BOFFSET = 4'd9,
    PH_DONE    = 4'd10,
    PH_FAILED  = 4'd11
  } phase_e;

  function automatic logic [2:0] next_chan(input logic [3:0] mask, input logic [2:0] from);
    logic [2:0] r;
    logic       found;
    r     = 3'd4;
    found = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (!found && (3'(c) >= from) && mask[c]) begin
        r     = 3'(c);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] set_chan(input logic [31:0] colour, input logic [1:0] ch,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = colour;
    r[{ch, 3'b000} +: 8] = b;
    return r;
  endfunction

  phase_e      phase_q, phase_c, phase_d;
  logic [1:0]  fbc_q, fbc_c, fbc_d;
  logic [7:0]  low_q, low_c, low_d;
  logic [3:0]  img_mask_q, img_mask_c, img_mask_d;
  logic [15:0] width_q, width_c, width_d;
  logic [15:0] height_q, height_c, height_d;
  logic [15:0] blocks_q, blocks_c, blocks_d;
  logic [3:0]  blk_mask_q, blk_mask_c, blk_mask_d;
  logic [31:0] colour_q, colour_c, colour_d;
  logic [15:0] offs_q, offs_c, offs_d;
  logic [31:0] rawcnt_q, rawcnt_c, rawcnt_d;
  logic        err_q, err_c, err_d;
  logic [31:0] total_q, total_c, total_d;

  // start of image restarts from the reset state on this very byte
  always_comb begin
    if (start_i) begin
      phase_c    = PH_ID;
      fbc_c      = '0;
      low_c      = '0;
      img_mask_c = '0;
      width_c    = '0;
      height_c   = '0;
      blocks_c   = '0;
      blk_mask_c = '0;
      colour_c   = COLOUR_DEFAULT;
      offs_c     = '0;
      rawcnt_c   = '0;
      err_c      = 1'b0;
      total_c    = '0;
    end else begin
      phase_c    = phase_q;
      fbc_c      = fbc_q;
      low_c      = low_q;
      img_mask_c = img_mask_q;
      width_c    = width_q;
      height_c   = height_q;
      blocks_c   = blocks_q;
      blk_mask_c = blk_mask_q;
      colour_c   = colour_q;
      offs_c     = offs_q;
      rawcnt_c   = rawcnt_q;
      err_c      = err_q;
      total_c    = total_q;
    end
  end

  logic [15:0] word;
  logic        word_done;
  logic [31:0] colour_set;
  logic [2:0]  nx_img;
  logic [2:0]  nx_blk;
  logic [2:0]  nx0_img;
  logic [2:0]  nx0_byte;
  logic        emit;
  kind_e       kind;
  logic [31:0] idx;
  logic [31:0] colour_out;
  logic [15:0] w_out;
  logic [15:0] h_out;
  err_e        ecode;
  logic        last;

  assign word       = {data_byte_i, low_c};
  assign word_done  = (fbc_c != 2'd0);
  assign colour_set = set_chan(colour_c, fbc_c, data_byte_i);
  assign nx_img     = next_chan(img_mask_c, {1'b0, fbc_c} + 3'd1);
  assign nx_blk     = next_chan(blk_mask_c, {1'b0, fbc_c} + 3'd1);
  assign nx0_img    = next_chan(img_mask_c, 3'd0);
  assign nx0_byte   = next_chan(data_byte_i[3:0], 3'd0);

  always_comb begin
    phase_d    = phase_c;
    fbc_d      = fbc_c;
    low_d      = low_c;
    img_mask_d = img_mask_c;
    width_d    = width_c;
    height_d   = height_c;
    blocks_d   = blocks_c;
    blk_mask_d = blk_mask_c;
    colour_d   = colour_c;
    offs_d     = offs_c;
    rawcnt_d   = rawcnt_c;
    err_d      = err_c;
    total_d    = total_c;
    emit       = 1'b0;
    kind       = KIND_HEADER;
    idx        = '0;
    colour_out = '0;
    w_out      = '0;
    h_out      = '0;
    ecode      = ERR_NONE;
    last       = 1'b0;

    // 16-bit fields: first byte is the low half
    if ((phase_c == PH_WIDTH || phase_c == PH_HEIGHT || phase_c == PH_NBLOCKS ||
         phase_c == PH_BCOUNT || phase_c == PH_BOFFSET) && !word_done) begin
      low_d = data_byte_i;
      fbc_d = 2'd1;
    end

    unique case (phase_c)
      PH_ID: begin
        if (data_byte_i != TAG_BYTES[fbc_c]) err_d = 1'b1;
        if (fbc_c == 2'd3) begin
          fbc_d = 2'd0;
          if (err_d) begin
            phase_d = PH_FAILED;
            emit    = 1'b1;
            kind    = KIND_ERROR;
            ecode   = ERR_BAD_ID;
            last    = 1'b1;
          end else begin
            phase_d = PH_FLAGS;
          end
        end else begin
          fbc_d = fbc_c + 2'd1;
        end
      end
      PH_FLAGS: begin
        img_mask_d = data_byte_i[3:0];
        fbc_d      = 2'd0;
        phase_d    = PH_WIDTH;
      end
      PH_WIDTH: begin
        if (word_done) begin
          fbc_d   = 2'd0;
          width_d = word;
          phase_d = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (word_done) begin
          fbc_d    = 2'd0;
          height_d = word;
          total_d  = {16'd0, width_c} * {16'd0, word};
          phase_d  = PH_NBLOCKS;
        end
      end
      PH_NBLOCKS: begin
        if (word_done) begin
          fbc_d    = 2'd0;
          blocks_d = word;
          emit     = 1'b1;
          kind     = KIND_HEADER;
          w_out    = width_c;
          h_out    = height_c;
          if (word != 16'd0) begin
            phase_d = PH_BFLAGS;
          end else if (total_c == 32'd0 || img_mask_c == 4'd0) begin
            phase_d = PH_DONE;
            last    = 1'b1;
          end else begin
            phase_d  = PH_RAW;
            rawcnt_d = '0;
            colour_d = '0;
            fbc_d    = nx0_img[1:0];
          end
        end
      end
      PH_RAW: begin
        if (!nx_img[2]) begin
          fbc_d    = nx_img[1:0];
          colour_d = colour_set;
        end else begin
          emit       = 1'b1;
          kind       = KIND_PIXEL;
          idx        = rawcnt_c;
          colour_out = colour_set;
          rawcnt_d   = rawcnt_c + 32'd1;
          colour_d   = '0;
          fbc_d      = nx0_img[1:0];
          if (rawcnt_d == total_c) begin
            phase_d = PH_DONE;
            last    = 1'b1;
          end
        end
      end
      PH_BFLAGS: begin
        blk_mask_d = data_byte_i[3:0];
        colour_d   = COLOUR_DEFAULT;
        if (data_byte_i[3:0] != 4'd0) begin
          fbc_d   = nx0_byte[1:0];
          phase_d = PH_BCOLOUR;
        end else begin
          fbc_d   = 2'd0;
          phase_d = PH_BCOUNT;
        end
      end
      PH_BCOLOUR: begin
        colour_d = colour_set;
        if (!nx_blk[2]) begin
          fbc_d = nx_blk[1:0];
        end else begin
          fbc_d   = 2'd0;
          phase_d = PH_BCOUNT;
        end
      end
      PH_BCOUNT: begin
        if (word_done) begin
          fbc_d  = 2'd0;
          offs_d = word;
          if (word != 16'd0) begin
            phase_d = PH_BOFFSET;
          end else begin
            blocks_d = blocks_c - 16'd1;
            if (blocks_d == 16'd0) begin
              phase_d = PH_DONE;
              emit    = 1'b1;
              kind    = KIND_END;
              last    = 1'b1;
            end else begin
              phase_d = PH_BFLAGS;
            end
          end
        end
      end
      PH_BOFFSET: begin
        if (word_done) begin
          fbc_d = 2'd0;
          emit  = 1'b1;
          if ({16'd0, word} >= total_c) begin
            err_d   = 1'b1;
            phase_d = PH_FAILED;
            kind    = KIND_ERROR;
            ecode   = ERR_OFFSET;
            last    = 1'b1;
          end else begin
            kind       = KIND_PIXEL;
            idx        = {16'd0, word};
            colour_out = colour_c;
            offs_d     = offs_c - 16'd1;
            if (offs_d == 16'd0) begin
              blocks_d = blocks_c - 16'd1;
              if (blocks_d == 16'd0) begin
                phase_d = PH_DONE;
                last    = 1'b1;
              end else begin
                phase_d = PH_BFLAGS;
              end
            end
          end
        end
      end
      PH_DONE, PH_FAILED: begin
        fbc_d = fbc_c;
      end
      default: begin
        phase_d = phase_c;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ID;
      fbc_q      <= '0;
      low_q      <= '0;
      img_mask_q <= '0;
      width_q    <= '0;
      height_q   <= '0;
      blocks_q   <= '0;
      blk_mask_q <= '0;
      colour_q   <= COLOUR_DEFAULT;
      offs_q     <= '0;
      rawcnt_q   <= '0;
      err_q      <= 1'b0;
      total_q    <= '0;
    end else if (acc_i) begin
      phase_q    <= phase_d;
      fbc_q      <= fbc_d;
      low_q      <= low_d;
      img_mask_q <= img_mask_d;
      width_q    <= width_d;
      height_q   <= height_d;
      blocks_q   <= blocks_d;
      blk_mask_q <= blk_mask_d;
      colour_q   <= colour_d;
      offs_q     <= offs_d;
      rawcnt_q   <= rawcnt_d;
      err_q      <= err_d;
      total_q    <= total_d;
    end
  end

  assign res_valid_o         = acc_i & emit;
  assign res_o.kind          = kind;
  assign res_o.pixel_index   = idx;
  assign res_o.red           = colour_out[7:0];
  assign res_o.green         = colour_out[15:8];
  assign res_o.blue          = colour_out[23:16];
  assign res_o.alpha         = colour_out[31:24];
  assign res_o.image_width   = w_out;
  assign res_o.image_height  = h_out;
  assign res_o.has_alpha     = img_mask_d[CHAN_ALPHA];
  assign res_o.error_code    = ecode;
  assign res_o.last_of_image = last;

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_ERROR) |->
      (res_o.last_of_image && res_o.error_code != ERR_NONE))
    else $error("error result without last mark or code");

  a_pixel_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_PIXEL) |-> (res_o.error_code == ERR_NONE))
    else $error("pixel result carries an error code");

  a_silent_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_of_image) |=> (!res_valid_o || start_i))
    else $error("result after end of image without new start");

  a_raw_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_PIXEL) |-> (res_o.pixel_index < total_c))
    else $error("pixel index beyond image size");

endmodule

// ===== rtl/pisd_obuf.sv =====
// ----------------------------------------------------------------------------
// pisd_obuf
// Two-entry result buffer: head register plus skid register.
// ----------------------------------------------------------------------------
module pisd_obuf import pisd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic room_o,
  output logic valid_o,
  output res_t data_o,
  input  logic ready_i
);

  logic head_v_q, head_v_d;
  logic spare_v_q, spare_v_d;
  res_t head_q, head_d;
  res_t spare_q, spare_d;
  logic pop;
  logic push;

  assign pop  = head_v_q & ready_i;
  assign push = push_i & ~spare_v_q;

  always_comb begin
    head_v_d  = head_v_q;
    spare_v_d = spare_v_q;
    head_d    = head_q;
    spare_d   = spare_q;
    if (pop) begin
      if (spare_v_q) begin
        head_d    = spare_q;
        spare_v_d = 1'b0;
      end else if (push) begin
        head_d = push_data_i;
      end else begin
        head_v_d = 1'b0;
      end
    end else if (push) begin
      if (head_v_q) begin
        spare_d   = push_data_i;
        spare_v_d = 1'b1;
      end else begin
        head_d   = push_data_i;
        head_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      head_v_q  <= head_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  assign room_o  = ~spare_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

  a_spare_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> head_v_q)
    else $error("skid entry held without head entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && spare_v_q) |-> 1'b0)
    else $error("result pushed into full buffer");

endmodule

// ===== rtl/packed_image_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// packed_image_stream_decoder_top
// Byte-serial decoder for packed GFX0 image files.
// ----------------------------------------------------------------------------
// in_i carries one file byte per request; start_of_image set on a request
// restarts parsing with that byte as the first tag byte. out_o carries at
// most one result per input byte: a header, a pixel write, an error or an
// end mark, with last_of_image set on the final result of the image.
// One input byte is taken every cycle while in_i.ready is high; each byte is
// parsed combinationally against the parser state registers. A result is
// presented on out_o from the head register, via the skid register if busy.
// Results go through a two-entry buffer (head and skid register), so input
// keeps flowing while one result waits; in_i.ready drops only when both
// entries are full, i.e. while the receiver stalls with two results held.
// Reset (rst_ni low) empties the buffer and puts the parser back to waiting
// for the tag; no start mark is needed for the first image after reset.
// ----------------------------------------------------------------------------
module packed_image_stream_decoder_top import pisd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pisd_in_if.sink    in_i,
  pisd_out_if.source out_o
);

  logic room;
  logic acc;
  logic res_valid;
  res_t res;
  res_t head;

  assign in_i.ready = room;
  assign acc        = in_i.valid & room;

  pisd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .data_byte_i (in_i.data_byte),
    .start_i     (in_i.start_of_image),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pisd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (out_o.valid),
    .data_o      (head),
    .ready_i     (out_o.ready)
  );

  assign out_o.kind          = head.kind;
  assign out_o.pixel_index   = head.pixel_index;
  assign out_o.red           = head.red;
  assign out_o.green         = head.green;
  assign out_o.blue          = head.blue;
  assign out_o.alpha         = head.alpha;
  assign out_o.image_width   = head.image_width;
  assign out_o.image_height  = head.image_height;
  assign out_o.has_alpha     = head.has_alpha;
  assign out_o.error_code    = head.error_code;
  assign out_o.last_of_image = head.last_of_image;

  a_result_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_o.valid)
    else $error("accepted result not presented");

  a_ready_with_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output");

  a_pixel_colour_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_PIXEL) |->
      (out_o.red == 8'd0 && out_o.green == 8'd0 && out_o.blue == 8'd0 &&
       out_o.alpha == 8'd0 && out_o.pixel_index == 32'd0))
    else $error("non-pixel result carries pixel data");

endmodule

// ===== verif/pisd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pisd_checker
// Watches the byte and result channels of the packed image decoder. A
// byte-level parser of its own tracks every accepted byte, queues the result
// request the decoder owes for it, and compares each result taken from the
// decoder against the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module pisd_checker import pisd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pisd_in_if   in_mon_i,
  pisd_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o,
  output int   pixel_writes_o
);

  typedef enum logic [3:0] {
    P_TAG, P_IMG_FLAGS, P_WIDTH, P_HEIGHT, P_BLOCK_COUNT, P_RAW_PIXELS,
    P_BLK_FLAGS, P_BLK_COLOUR, P_OFFSET_COUNT, P_OFFSETS, P_DONE, P_ABANDONED
  } parse_e;

  parse_e      phase;
  logic [1:0]  byte_sel;
  logic [7:0]  low_byte;
  logic [3:0]  img_mask;
  logic [3:0]  blk_mask;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [15:0] blocks_rem;
  logic [15:0] offsets_rem;
  logic [31:0] colour;
  logic [31:0] raw_idx;
  logic        tag_bad;

  res_t owed_results_q[$];
  int   mismatches = 0;
  int   n_results  = 0;
  int   n_pixels   = 0;

  function automatic void clear_parser();
    phase       = P_TAG;
    byte_sel    = '0;
    low_byte    = '0;
    img_mask    = '0;
    blk_mask    = '0;
    img_w       = '0;
    img_h       = '0;
    blocks_rem  = '0;
    offsets_rem = '0;
    colour      = COLOUR_DEFAULT;
    raw_idx     = '0;
    tag_bad     = 1'b0;
  endfunction

  function automatic int first_chan(input logic [3:0] mask, input int from);
    for (int c = from; c < 4; c++) begin
      if (mask[c]) return c;
    end
    return 4;
  endfunction

  function automatic logic [31:0] pixel_count();
    return 32'(img_w) * 32'(img_h);
  endfunction

  function automatic bit word_done(input logic [7:0] b, output logic [15:0] w);
    w = '0;
    if (byte_sel == 2'd0) begin
      low_byte = b;
      byte_sel = 2'd1;
      return 1'b0;
    end
    byte_sel = 2'd0;
    w = {b, low_byte};
    return 1'b1;
  endfunction

  function automatic bit close_block();
    blocks_rem = blocks_rem - 16'd1;
    if (blocks_rem == 16'd0) begin
      phase = P_DONE;
      return 1'b1;
    end
    phase = P_BLK_FLAGS;
    return 1'b0;
  endfunction

  function automatic res_t make_result(input kind_e k, input logic [31:0] idx,
                                       input logic [31:0] col, input logic [15:0] w,
                                       input logic [15:0] h, input err_e e,
                                       input logic last);
    res_t r;
    r.kind          = k;
    r.pixel_index   = idx;
    r.red           = col[7:0];
    r.green         = col[15:8];
    r.blue          = col[23:16];
    r.alpha         = col[31:24];
    r.image_width   = w;
    r.image_height  = h;
    r.has_alpha     = img_mask[CHAN_ALPHA];
    r.error_code    = e;
    r.last_of_image = last;
    return r;
  endfunction

  // one byte through the parser; returns 1 when it owes a result
  function automatic bit decode_byte(input logic [7:0] b, input logic sof, output res_t r);
    logic [15:0] w;
    int          nx;
    r = '0;
    if (sof) clear_parser();
    case (phase)
      P_TAG: begin
        if (b != TAG_BYTES[byte_sel]) tag_bad = 1'b1;
        if (byte_sel == 2'd3) begin
          byte_sel = 2'd0;
          if (tag_bad) begin
            phase = P_ABANDONED;
            r = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_BAD_ID, 1'b1);
            return 1'b1;
          end
          phase = P_IMG_FLAGS;
        end else begin
          byte_sel = byte_sel + 2'd1;
        end
        return 1'b0;
      end
      P_IMG_FLAGS: begin
        img_mask = b[3:0];
        byte_sel = 2'd0;
        phase    = P_WIDTH;
        return 1'b0;
      end
      P_WIDTH: begin
        if (word_done(b, w)) begin
          img_w = w;
          phase = P_HEIGHT;
        end
        return 1'b0;
      end
      P_HEIGHT: begin
        if (word_done(b, w)) begin
          img_h = w;
          phase = P_BLOCK_COUNT;
        end
        return 1'b0;
      end
      P_BLOCK_COUNT: begin
        if (!word_done(b, w)) return 1'b0;
        blocks_rem = w;
        if (w != 16'd0) begin
          phase = P_BLK_FLAGS;
          r = make_result(KIND_HEADER, '0, '0, img_w, img_h, ERR_NONE, 1'b0);
          return 1'b1;
        end
        if (pixel_count() == 32'd0 || img_mask == 4'd0) begin
          phase = P_DONE;
          r = make_result(KIND_HEADER, '0, '0, img_w, img_h, ERR_NONE, 1'b1);
          return 1'b1;
        end
        phase    = P_RAW_PIXELS;
        raw_idx  = '0;
        colour   = '0;
        byte_sel = 2'(first_chan(img_mask, 0));
        r = make_result(KIND_HEADER, '0, '0, img_w, img_h, ERR_NONE, 1'b0);
        return 1'b1;
      end
      P_RAW_PIXELS: begin
        colour[byte_sel*8 +: 8] = b;
        nx = first_chan(img_mask, int'(byte_sel) + 1);
        if (nx < 4) begin
          byte_sel = 2'(nx);
          return 1'b0;
        end
        r = make_result(KIND_PIXEL, raw_idx, colour, '0, '0, ERR_NONE, 1'b0);
        raw_idx  = raw_idx + 32'd1;
        colour   = '0;
        byte_sel = 2'(first_chan(img_mask, 0));
        if (raw_idx == pixel_count()) begin
          phase = P_DONE;
          r.last_of_image = 1'b1;
        end
        return 1'b1;
      end
      P_BLK_FLAGS: begin
        blk_mask = b[3:0];
        colour   = COLOUR_DEFAULT;
        if (blk_mask != 4'd0) begin
          byte_sel = 2'(first_chan(blk_mask, 0));
          phase    = P_BLK_COLOUR;
        end else begin
          byte_sel = 2'd0;
          phase    = P_OFFSET_COUNT;
        end
        return 1'b0;
      end
      P_BLK_COLOUR: begin
        colour[byte_sel*8 +: 8] = b;
        nx = first_chan(blk_mask, int'(byte_sel) + 1);
        if (nx < 4) begin
          byte_sel = 2'(nx);
        end else begin
          byte_sel = 2'd0;
          phase    = P_OFFSET_COUNT;
        end
        return 1'b0;
      end
      P_OFFSET_COUNT: begin
        if (!word_done(b, w)) return 1'b0;
        offsets_rem = w;
        if (w != 16'd0) begin
          phase = P_OFFSETS;
          return 1'b0;
        end
        if (close_block()) begin
          r = make_result(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      P_OFFSETS: begin
        if (!word_done(b, w)) return 1'b0;
        if (32'(w) >= pixel_count()) begin
          tag_bad = 1'b1;
          phase   = P_ABANDONED;
          r = make_result(KIND_ERROR, '0, '0, '0, '0, ERR_OFFSET, 1'b1);
          return 1'b1;
        end
        offsets_rem = offsets_rem - 16'd1;
        r = make_result(KIND_PIXEL, 32'(w), colour, '0, '0, ERR_NONE, 1'b0);
        if (offsets_rem == 16'd0 && close_block()) r.last_of_image = 1'b1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns result %0d: %s", $time, n_results, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin
    res_t want;
    res_t pred;
    if (!rst_ni) begin
      clear_parser();
      owed_results_q.delete();
    end else begin
      // results are compared before this edge's byte is parsed
      if (out_mon_i.valid && out_mon_i.ready) begin
        n_results++;
        if (out_mon_i.kind == KIND_PIXEL) n_pixels++;
        if (owed_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result of kind %0d", out_mon_i.kind));
        end else begin
          want = owed_results_q.pop_front();
          compare_field("kind", 32'(out_mon_i.kind), 32'(want.kind));
          compare_field("pixel_index", out_mon_i.pixel_index, want.pixel_index);
          compare_field("red", 32'(out_mon_i.red), 32'(want.red));
          compare_field("green", 32'(out_mon_i.green), 32'(want.green));
          compare_field("blue", 32'(out_mon_i.blue), 32'(want.blue));
          compare_field("alpha", 32'(out_mon_i.alpha), 32'(want.alpha));
          compare_field("image_width", 32'(out_mon_i.image_width),
                        32'(want.image_width));
          compare_field("image_height", 32'(out_mon_i.image_height),
                        32'(want.image_height));
          compare_field("has_alpha", 32'(out_mon_i.has_alpha), 32'(want.has_alpha));
          compare_field("error_code", 32'(out_mon_i.error_code), 32'(want.error_code));
          compare_field("last_of_image", 32'(out_mon_i.last_of_image),
                        32'(want.last_of_image));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (decode_byte(in_mon_i.data_byte, in_mon_i.start_of_image, pred))
          owed_results_q.push_back(pred);
      end
    end
    fail_count_o   <= mismatches;
    pending_o      <= owed_results_q.size();
    results_o      <= n_results;
    pixel_writes_o <= n_pixels;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-stream test of the packed image stream decoder. A few hand-built
// files open the run: an image sent without a start mark, unused flag bits,
// a bad tag and an empty final block. Random files follow, mostly
// well-formed raw and block images with random content, mixed with bad tags,
// cut-off files, stray bytes and noise, under four idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
  import pisd_pkg::*;

  localparam int BYTE_GOAL    = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;

  pisd_in_if  in_if ();
  pisd_out_if out_if ();

  int fails;
  int pending;
  int results;
  int pixels;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int cycle_cnt  = 0;

  logic [7:0] file_q[$];

  packed_image_stream_decoder_top uut (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  pisd_checker chk (
    .clk_i,
    .rst_ni,
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .results_o      (results),
    .pixel_writes_o (pixels)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic sof);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.data_byte      <= b;
    in_if.start_of_image <= sof;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_file(input logic sof);
    foreach (file_q[i]) send_byte(file_q[i], sof && (i == 0));
    bytes_sent += file_q.size();
    files_sent++;
  endtask

  function automatic void put_word(input logic [15:0] w);
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
  endfunction

  function automatic void put_header(input logic [7:0] flags, input logic [15:0] w,
                                     input logic [15:0] h, input logic [15:0] nb);
    foreach (TAG_BYTES[i]) file_q.push_back(TAG_BYTES[i]);
    file_q.push_back(flags);
    put_word(w);
    put_word(h);
    put_word(nb);
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic void build_raw_image();
    logic [7:0]  flags;
    logic [15:0] w;
    logic [15:0] h;
    int          n;
    flags = 8'($urandom);
    w     = 16'($urandom_range(0, 4));
    h     = 16'($urandom_range(0, 4));
    // empty image with any size in the other dimension
    if ($urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) begin
        w = 16'($urandom);
        h = 16'h0000;
      end else begin
        w = 16'h0000;
        h = 16'($urandom);
      end
    end
    put_header(flags, w, h, 16'h0000);
    n = int'(w) * int'(h) * $countones(flags[3:0]);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void build_block_image();
    logic [7:0]  flags;
    logic [7:0]  blk_flags;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] nb;
    logic [15:0] cnt;
    logic [31:0] total;
    int          nb_made;
    int          cnt_made;
    flags = 8'($urandom);
    w     = pick_dim();
    h     = pick_dim();
    nb    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(4, 65535))
                                        : 16'($urandom_range(1, 3));
    put_header(flags, w, h, nb);
    total   = 32'(w) * 32'(h);
    nb_made = (nb > 16'd3) ? 3 : int'(nb);
    for (int i = 0; i < nb_made; i++) begin
      blk_flags = 8'($urandom);
      file_q.push_back(blk_flags);
      repeat ($countones(blk_flags[3:0])) file_q.push_back(8'($urandom));
      cnt = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 65535))
                                        : 16'($urandom_range(0, 4));
      put_word(cnt);
      cnt_made = (cnt > 16'd4) ? 4 : int'(cnt);
      repeat (cnt_made) begin
        if (total == 32'd0 || $urandom_range(0, 19) == 0)
          put_word(16'($urandom));
        else
          put_word(16'($urandom_range(0, (total > 32'd65536) ? 65535 : total - 1)));
      end
      // declared more offsets than sent: file ends here
      if (cnt_made < int'(cnt)) return;
    end
  endfunction

  function automatic void build_bad_tag();
    int pos;
    pos = $urandom_range(0, 3);
    foreach (TAG_BYTES[i]) begin
      if (i == pos) file_q.push_back(TAG_BYTES[i] ^ 8'($urandom_range(1, 255)));
      else          file_q.push_back(TAG_BYTES[i]);
    end
    repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
  endfunction

  initial begin
    int pick;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.data_byte      <= 8'h00;
    in_if.start_of_image <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first image without a start mark, unused flag bits, empty raw image
    put_header(8'hF0, 16'hFFFF, 16'h0000, 16'h0000);
    send_file(1'b0);
    send_byte(8'hFF, 1'b0);

    // bad last tag byte
    file_q = '{TAG_BYTES[0], TAG_BYTES[1], TAG_BYTES[2], 8'h31};
    send_file(1'b1);

    // full colour block, then an empty final block
    file_q.delete();
    put_header(8'h08, 16'h0001, 16'h0001, 16'h0002);
    file_q.push_back(8'hFF);
    put_word(16'hFF00);
    put_word(16'hFF00);
    put_word(16'h0001);
    put_word(16'h0000);
    file_q.push_back(8'h00);
    put_word(16'h0000);
    send_file(1'b1);

    while (bytes_sent < BYTE_GOAL) begin
      case (bytes_sent * 4 / BYTE_GOAL)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 27;
          stall_pct = 27;
        end
      endcase
      file_q.delete();
      pick = $urandom_range(0, 19);
      if (pick < 2)       repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
      else if (pick < 4)  build_bad_tag();
      else if (pick < 11) build_raw_image();
      else                build_block_image();
      // cut-off file
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(0, file_q.size() - 1)) void'(file_q.pop_back());
      send_file((pick >= 2) || ($urandom_range(0, 1) == 1));
      // stray bytes past the end
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d bytes in %0d files across four idle/stall mixes",
             bytes_sent, files_sent);
    $display("checked %0d results, %0d of them pixel writes", results, pixels);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pisd_pkg.sv
rtl/pisd_in_if.sv
rtl/pisd_out_if.sv
rtl/pisd_parser.sv
rtl/pisd_obuf.sv
rtl/packed_image_stream_decoder_top.sv
verif/pisd_checker.sv
verif/tb.sv
